>>> src/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Sizes shared by the queue and its stream ports.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int DEPTH = 16;
   localparam int VALUE_W = 32;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);
   localparam int COUNT_OUT_W = 5;

   localparam int REQ_BITS = 1 + VALUE_W;
   localparam int REQ_DATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS = 1 + VALUE_W + 1 + COUNT_OUT_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   typedef logic [REQ_DATA_W-1:0] req_data_type;
   typedef logic [RSP_DATA_W-1:0] rsp_data_type;

endpackage

>>> src/sorted_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue
// Keeps up to DEPTH signed values in descending order in a memory with one read
// and one write port, walking it one entry a cycle to insert or remove a value.
// ----------------------------------------------------------------------------
// An insert walks the entry memory from the tail towards the head, and a remove
// walks it from the head, at one read and one write per cycle; DEPTH is 16.
// Throughput: one transaction at a time; the next is accepted once the result
// has been loaded into the output register. Reset empties the queue at once.
module sorted_priority_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [0] command, [32:1] item_value, [39:33] zero
   input  spq_pkg::req_data_type req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] done_ok, [32:1] head_value, [33] head_valid, [38:34] entry_count,
   // [39] zero
   output spq_pkg::rsp_data_type rsp_tdata
);
   import spq_pkg::*;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_INS      = 3'd1;
   localparam logic [2:0] ST_INS_LAST = 3'd2;
   localparam logic [2:0] ST_REM      = 3'd3;
   localparam logic [2:0] ST_DONE     = 3'd4;

   logic [VALUE_W-1:0] entry_mem [DEPTH];
   logic [VALUE_W-1:0] rdata_ff;

   logic [2:0]         state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic               found_ff, found_in;
   logic               ok_ff, ok_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [VALUE_W-1:0] head_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_data_type       rsp_data_ff, rsp_data_in;

   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   logic [VALUE_W-1:0] mem_wdata;
   logic [IDX_W-1:0]   mem_raddr;
   logic               req_fire;
   logic               found_now;
   logic [CNT_W-1:0]   addr_wide;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign found_now = found_ff || (rdata_ff == value_ff);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      found_in = found_ff;
      ok_in = ok_ff;
      value_in = value_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      mem_we = 1'b0;
      mem_waddr = '0;
      mem_wdata = value_ff;
      addr_wide = '0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               value_in = req_tdata[VALUE_W:1];
               found_in = 1'b0;
               if (req_tdata[0] == CMD_INSERT) begin
                  if (count_ff >= CNT_W'(DEPTH)) begin
                     ok_in = 1'b0;
                     state_in = ST_DONE;
                  end else if (count_ff == '0) begin
                     mem_we = 1'b1;
                     mem_waddr = '0;
                     mem_wdata = req_tdata[VALUE_W:1];
                     count_in = count_ff + 1'b1;
                     ok_in = 1'b1;
                     state_in = ST_DONE;
                  end else begin
                     addr_wide = count_ff - 1'b1;
                     idx_in = count_ff;
                     state_in = ST_INS;
                  end
               end else begin
                  idx_in = '0;
                  if (count_ff == '0) begin
                     ok_in = 1'b0;
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_REM;
                  end
               end
            end
         end
         ST_INS: begin
            mem_we = 1'b1;
            mem_waddr = idx_ff[IDX_W-1:0];
            addr_wide = idx_ff - CNT_W'(2);
            if ($signed(rdata_ff) < $signed(value_ff)) begin
               mem_wdata = rdata_ff;
               idx_in = idx_ff - 1'b1;
               if (idx_ff == CNT_W'(1)) begin
                  state_in = ST_INS_LAST;
               end
            end else begin
               mem_wdata = value_ff;
               count_in = count_ff + 1'b1;
               ok_in = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_INS_LAST: begin
            mem_we = 1'b1;
            mem_waddr = '0;
            mem_wdata = value_ff;
            count_in = count_ff + 1'b1;
            ok_in = 1'b1;
            state_in = ST_DONE;
         end
         ST_REM: begin
            addr_wide = idx_ff + 1'b1;
            mem_we = found_ff;
            mem_waddr = IDX_W'(idx_ff - 1'b1);
            mem_wdata = rdata_ff;
            found_in = found_now;
            if (idx_ff == count_ff - 1'b1) begin
               count_in = count_ff - CNT_W'(found_now);
               ok_in = found_now;
               state_in = ST_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = '0;
               rsp_data_in[0] = ok_ff;
               rsp_data_in[VALUE_W:1] = (count_ff != '0) ? head_ff : '0;
               rsp_data_in[VALUE_W+1] = (count_ff != '0);
               rsp_data_in[VALUE_W+2 +: COUNT_OUT_W] = COUNT_OUT_W'(count_ff);
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      mem_raddr = addr_wide[IDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= entry_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      found_ff <= found_in;
      ok_ff <= ok_in;
      value_ff <= value_in;
      rsp_data_ff <= rsp_data_in;
      if (mem_we && mem_waddr == '0) begin
         head_ff <= mem_wdata;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count exceeds the queue depth");

   a_insert_not_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INS || state_ff == ST_INS_LAST) |-> count_ff < CNT_W'(DEPTH))
      else $error("insert walk started on a full queue");

   a_remove_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_REM |-> idx_ff < count_ff)
      else $error("remove walk ran past the stored entries");

   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && (!rsp_valid_ff || rsp_tready)) |=> rsp_valid_ff)
      else $error("finished transaction did not reach the output register");
`endif

endmodule
